@@ sv/assert_macros.svh @@
// Assertion helpers shared by the top level and the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TIC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define TIC_ASSERT(lbl, prop, msg) `TIC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ sv/tic_pkg.sv @@
`default_nettype none

package tic_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int PIX_W      = 16;
  localparam int DIM_W      = 13;
  localparam int THR_W      = 16;
  localparam int CTR_W      = 20;
  localparam int POS_W      = $clog2(MAX_DIM);
  localparam int SUM_W      = 56;
  localparam int WSUM_W     = 40;
  localparam int PROD_W     = POS_W + PIXEL_BITS;
  localparam int DVD_W      = SUM_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THRESHOLD = 2'd2;

  typedef struct packed {
    logic mul_en;
    logic mul_sel_y;
    logic add_x;
    logic add_y;
    logic clear;
  } tic_mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tic_div_st_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/tic_if.sv @@
`default_nettype none

interface tic_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tic_pkg::CFG_IDX_W-1:0]  index;
  logic [tic_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface tic_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [tic_pkg::PIX_W-1:0] pixel_value;

  modport source(output valid, pixel_value, input ready);
  modport sink(input valid, pixel_value, output ready);
endinterface

interface tic_result_if;
  logic                      valid;
  logic                      ready;
  logic [tic_pkg::CTR_W-1:0] centre_x;
  logic [tic_pkg::CTR_W-1:0] centre_y;
  logic                      empty_frame;

  modport source(output valid, centre_x, centre_y, empty_frame, input ready);
  modport sink(input valid, centre_x, centre_y, empty_frame, output ready);
endinterface

`default_nettype wire

@@ sv/thresholded_intensity_centroid_top.sv @@
// Channel   Direction  Payload
// cfg_i     in         index, data (frame_width, frame_height, weight_threshold)
// pixel_i   in         pixel_value
// result_o  out        centre_x, centre_y, empty_frame
//
// A pixel goes through acceptance, two passes through the shared multiplier
// and a final accumulate. A frame's last pixel adds two divisions and an emit
// step, or only the emit step when the frame carries no weight.
// Reset restores the default frame size and a zero threshold and clears all sums.
// A result waits in its register while the next frame's pixels are accepted;
// the block stalls only when a new result finds the register still full.
`default_nettype none

`include "assert_macros.svh"

module thresholded_intensity_centroid_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  tic_cfg_if.sink       cfg_i,
  tic_pixel_if.sink     pixel_i,
  tic_result_if.source  result_o
);
  import tic_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_ADD_Y,
    S_DIV_X,
    S_DIV_Y,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [THR_W-1:0]  thr_q;
  logic [POS_W-1:0]  x_pos_q;
  logic [POS_W-1:0]  y_pos_q;
  logic [POS_W-1:0]  cur_x_q;
  logic [POS_W-1:0]  cur_y_q;
  logic [PIXEL_BITS-1:0] weight_q;
  logic              frame_end_q;
  logic [CTR_W-1:0]  cx_q;
  logic [CTR_W-1:0]  cy_q;
  logic              empty_q;
  logic              res_valid_q;
  logic [CTR_W-1:0]  res_x_q;
  logic [CTR_W-1:0]  res_y_q;
  logic              res_empty_q;

  logic [PIXEL_BITS-1:0] pix;
  logic [DIM_W-1:0]  w_last;
  logic [DIM_W-1:0]  h_last;
  logic              last_x;
  logic              last_y;
  logic              pix_acc;
  logic              emit_ok;
  tic_mac_ctrl_t     mac_ctrl;
  logic [SUM_W-1:0]  x_sum;
  logic [SUM_W-1:0]  y_sum;
  logic [WSUM_W-1:0] w_sum;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  tic_div_st_t       div_st;
  logic [CTR_W-1:0]  div_quot;

  assign cfg_i.ready   = 1'b1;
  assign pixel_i.ready = (state_q == S_IDLE);
  assign pix_acc       = pixel_i.valid && (state_q == S_IDLE);
  assign emit_ok       = !res_valid_q || result_o.ready;

  assign pix    = pixel_i.pixel_value[PIXEL_BITS-1:0];
  assign w_last = eff_dim(width_q) - 1'b1;
  assign h_last = eff_dim(height_q) - 1'b1;
  assign last_x = DIM_W'(x_pos_q) >= w_last;
  assign last_y = DIM_W'(y_pos_q) >= h_last;

  always_comb begin
    mac_ctrl           = '0;
    mac_ctrl.mul_en    = (state_q == S_MUL_X) || (state_q == S_MUL_Y);
    mac_ctrl.mul_sel_y = (state_q == S_MUL_Y);
    mac_ctrl.add_x     = (state_q == S_MUL_Y);
    mac_ctrl.add_y     = (state_q == S_ADD_Y);
    mac_ctrl.clear     = (state_q == S_EMIT) && emit_ok;
  end

  assign div_start = ((state_q == S_ADD_Y) && frame_end_q && (w_sum != '0)) ||
                     ((state_q == S_DIV_X) && div_st.done);
  assign div_dividend = (state_q == S_DIV_X) ? (DVD_W'(y_sum) << FRAC_BITS)
                                             : (DVD_W'(x_sum) << FRAC_BITS);

  tic_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .pos_x_i  (cur_x_q),
    .pos_y_i  (cur_y_q),
    .weight_i (weight_q),
    .x_sum_o  (x_sum),
    .y_sum_o  (y_sum),
    .w_sum_o  (w_sum)
  );

  tic_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (w_sum),
    .status_o   (div_st),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      thr_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_FRAME_WIDTH:      width_q  <= cfg_i.data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:     height_q <= cfg_i.data[DIM_W-1:0];
        CFG_WEIGHT_THRESHOLD: thr_q    <= cfg_i.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      cur_x_q  <= x_pos_q;
      cur_y_q  <= y_pos_q;
      weight_q <= (THR_W'(pix) < thr_q) ? '0 : pix;
    end
    if ((state_q == S_ADD_Y) && frame_end_q) begin
      cx_q    <= '0;
      cy_q    <= '0;
      empty_q <= (w_sum == '0);
    end
    if ((state_q == S_DIV_X) && div_st.done) begin
      cx_q <= div_quot;
    end
    if ((state_q == S_DIV_Y) && div_st.done) begin
      cy_q <= div_quot;
    end
    if ((state_q == S_EMIT) && emit_ok) begin
      res_x_q     <= cx_q;
      res_y_q     <= cy_q;
      res_empty_q <= empty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_pos_q     <= '0;
      y_pos_q     <= '0;
      frame_end_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ((state_q == S_EMIT) && emit_ok) || (res_valid_q && !result_o.ready);
      unique case (state_q)
        S_IDLE: begin
          if (pix_acc) begin
            frame_end_q <= last_x && last_y;
            if (last_x && last_y) begin
              x_pos_q <= '0;
              y_pos_q <= '0;
            end else if (last_y) begin
              x_pos_q <= x_pos_q + 1'b1;
              y_pos_q <= '0;
            end else begin
              y_pos_q <= y_pos_q + 1'b1;
            end
            state_q <= S_MUL_X;
          end
        end
        S_MUL_X: state_q <= S_MUL_Y;
        S_MUL_Y: state_q <= S_ADD_Y;
        S_ADD_Y: begin
          if (!frame_end_q) begin
            state_q <= S_IDLE;
          end else if (w_sum == '0) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_st.done) begin
            state_q <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_st.done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.centre_x    = res_x_q;
  assign result_o.centre_y    = res_y_q;
  assign result_o.empty_frame = res_empty_q;

  `TIC_ASSERT(a_result_from_emit, $rose(res_valid_q) |-> $past(state_q == S_EMIT), "result raised outside emit")
  `TIC_ASSERT(a_empty_zero, (res_valid_q && res_empty_q) |-> (res_x_q == '0 && res_y_q == '0), "empty frame with nonzero centre")
  `TIC_ASSERT(a_div_in_div_states, div_st.busy |-> (state_q == S_DIV_X || state_q == S_DIV_Y), "divider busy outside division")
  `TIC_ASSERT(a_frame_cleared, (state_q == S_EMIT) |-> (x_pos_q == '0 && y_pos_q == '0), "scan position not cleared at frame end")

endmodule

`default_nettype wire

@@ sv/tic_mac.sv @@
`default_nettype none

module tic_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tic_pkg::tic_mac_ctrl_t        ctrl_i,
  input  wire logic [tic_pkg::POS_W-1:0]     pos_x_i,
  input  wire logic [tic_pkg::POS_W-1:0]     pos_y_i,
  input  wire logic [tic_pkg::PIXEL_BITS-1:0] weight_i,
  output logic      [tic_pkg::SUM_W-1:0]     x_sum_o,
  output logic      [tic_pkg::SUM_W-1:0]     y_sum_o,
  output logic      [tic_pkg::WSUM_W-1:0]    w_sum_o
);
  import tic_pkg::*;

  logic [POS_W-1:0]  mul_a;
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  x_sum_q;
  logic [SUM_W-1:0]  y_sum_q;
  logic [WSUM_W-1:0] w_sum_q;

  // One multiplier serves both coordinates on successive cycles.
  assign mul_a = ctrl_i.mul_sel_y ? pos_y_i : pos_x_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(weight_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_sum_q <= '0;
      y_sum_q <= '0;
      w_sum_q <= '0;
    end else if (ctrl_i.clear) begin
      x_sum_q <= '0;
      y_sum_q <= '0;
      w_sum_q <= '0;
    end else begin
      if (ctrl_i.add_x) begin
        x_sum_q <= x_sum_q + SUM_W'(prod_q);
        w_sum_q <= w_sum_q + WSUM_W'(weight_i);
      end
      if (ctrl_i.add_y) begin
        y_sum_q <= y_sum_q + SUM_W'(prod_q);
      end
    end
  end

  assign x_sum_o = x_sum_q;
  assign y_sum_o = y_sum_q;
  assign w_sum_o = w_sum_q;

endmodule

`default_nettype wire

@@ sv/tic_div.sv @@
`default_nettype none

`include "assert_macros.svh"

module tic_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [tic_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [tic_pkg::WSUM_W-1:0] divisor_i,
  output tic_pkg::tic_div_st_t            status_o,
  output logic      [tic_pkg::CTR_W-1:0]  quotient_o
);
  import tic_pkg::*;

  logic [WSUM_W-1:0]    rem_q;
  logic [WSUM_W-1:0]    dsr_q;
  logic [DVD_W-1:0]     dvd_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [WSUM_W:0]      rem_sh;
  logic [WSUM_W:0]      diff;
  logic                 fits;

  // Restoring division, one quotient bit per cycle; quotient bits shift
  // into the dividend register from the bottom.
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign fits   = !diff[WSUM_W];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        cnt_q <= DIV_CNT_W'(DVD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q[CTR_W-1:0];

  `TIC_ASSERT(a_start_idle, start_i |-> (cnt_q == '0), "division started while busy")
  `TIC_ASSERT(a_done_after_last, done_q |-> (cnt_q == '0) && $past(cnt_q == DIV_CNT_W'(1)), "done without final step")
  `TIC_ASSERT(a_cnt_in_range, cnt_q <= DIV_CNT_W'(DVD_W), "division step count out of range")

endmodule

`default_nettype wire
